/* hw/rtl/filt_pkg.sv */
// ----------------------------------------------------------------------------
// filt_pkg
// Shared types and constants of the frontlight idle and lock light timer:
// event codes, register indexes, reset values and the packed records that
// pass between the configuration, evaluation and top-level modules.
// ----------------------------------------------------------------------------
package filt_pkg;

  // event codes carried in the operation field
  typedef enum logic [2:0] {
    OP_START       = 3'd0,
    OP_STOP        = 3'd1,
    OP_UPDATE      = 3'd2,
    OP_ACTIVITY    = 3'd3,
    OP_POWER       = 3'd4,
    OP_INTERACTION = 3'd5,
    OP_TOGGLE      = 3'd6,
    OP_SET_LOCK    = 3'd7
  } op_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_BRIGHTNESS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIMMED_BRIGHTNESS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIM_TIMEOUT       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_TIMEOUT       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCK_TIMEOUT      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERACTION_DUR   = 3'd5;

  // register reset values
  localparam logic [7:0]  RST_ACTIVE_BRIGHTNESS = 8'd255;
  localparam logic [7:0]  RST_DIMMED_BRIGHTNESS = 8'd32;
  localparam logic [31:0] RST_DIM_TIMEOUT       = 32'd30000;
  localparam logic [31:0] RST_OFF_TIMEOUT       = 32'd60000;
  localparam logic [31:0] RST_LOCK_TIMEOUT      = 32'd10000;
  localparam logic [31:0] RST_INTERACTION_DUR   = 32'd5000;

  // floor on the locked light duration after a power connection change
  localparam logic [31:0] POWER_CHANGE_MIN_MS = 32'd5000;

  // stream widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;

  typedef struct packed {
    logic [7:0]  active_brightness;
    logic [7:0]  dimmed_brightness;
    logic [31:0] dim_timeout_ms;
    logic [31:0] off_timeout_ms;
    logic [31:0] lock_timeout_ms;
    logic [31:0] interaction_duration_ms;
  } cfg_t;

  typedef struct packed {
    logic        running;
    logic        locked;
    logic        has_locked;
    logic        interaction_light;
    logic [31:0] last_activity_ms;
    logic [31:0] locked_duration_ms;
    logic [7:0]  light_level;
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] now_ms;
    logic        light_ready;
    logic        button_pressed;
    logic        input_activity;
    logic        lock_request;
    logic        reason_manual;
  } item_t;

  typedef struct packed {
    logic       idle_lock_due;
    logic       is_locked;
    logic       is_running;
    logic       start_ok;
    logic       brightness_written;
    logic [7:0] brightness;
  } result_t;

endpackage

/* hw/rtl/filt_cfg.sv */
// ----------------------------------------------------------------------------
// filt_cfg
// Configuration register file: six write-only registers loaded through a
// plain write port, returned to their defaults by reset.
// ----------------------------------------------------------------------------
module filt_cfg
  import filt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_brightness       <= RST_ACTIVE_BRIGHTNESS;
      cfg.dimmed_brightness       <= RST_DIMMED_BRIGHTNESS;
      cfg.dim_timeout_ms          <= RST_DIM_TIMEOUT;
      cfg.off_timeout_ms          <= RST_OFF_TIMEOUT;
      cfg.lock_timeout_ms         <= RST_LOCK_TIMEOUT;
      cfg.interaction_duration_ms <= RST_INTERACTION_DUR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_BRIGHTNESS: cfg.active_brightness       <= cfg_data[7:0];
        REG_DIMMED_BRIGHTNESS: cfg.dimmed_brightness       <= cfg_data[7:0];
        REG_DIM_TIMEOUT:       cfg.dim_timeout_ms          <= cfg_data;
        REG_OFF_TIMEOUT:       cfg.off_timeout_ms          <= cfg_data;
        REG_LOCK_TIMEOUT:      cfg.lock_timeout_ms         <= cfg_data;
        REG_INTERACTION_DUR:   cfg.interaction_duration_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/filt_event.sv */
// ----------------------------------------------------------------------------
// filt_event
// Event evaluation: from the current timer state, the configuration and one
// registered event, works out the next state and the result record.
// ----------------------------------------------------------------------------
module filt_event
  import filt_pkg::*;
(
  input  state_t  st,
  input  cfg_t    cfg,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic [31:0] idle;
  logic [31:0] idle_chk;
  logic [31:0] idle_after;
  logic [31:0] remaining;
  logic        act_update;
  logic        wrote;
  logic        start_ok;
  state_t      nxt;

  assign idle = item.now_ms - st.last_activity_ms;

  // per-event state update
  always_comb begin
    nxt        = st;
    wrote      = 1'b0;
    start_ok   = 1'b0;
    act_update = 1'b0;
    idle_chk   = idle;
    remaining  = '0;
    case (item.operation)
      OP_START: begin
        if (st.running) begin
          start_ok = 1'b1;
        end else if (item.light_ready) begin
          nxt.running           = 1'b1;
          nxt.locked            = 1'b0;
          nxt.has_locked        = 1'b0;
          nxt.interaction_light = 1'b0;
          nxt.last_activity_ms  = item.now_ms;
          nxt.light_level       = cfg.active_brightness;
          wrote                 = 1'b1;
          start_ok              = 1'b1;
        end
      end
      OP_STOP: begin
        nxt.running = 1'b0;
      end
      OP_UPDATE: begin
        if (st.running) begin
          act_update = !item.button_pressed && item.input_activity && !st.locked;
          if (act_update) begin
            nxt.last_activity_ms = item.now_ms;
            nxt.light_level      = cfg.active_brightness;
            wrote                = 1'b1;
            idle_chk             = '0;
          end
          // timeout check at the same time stamp
          if (st.locked) begin
            if (idle_chk >= st.locked_duration_ms) begin
              nxt.light_level       = '0;
              nxt.interaction_light = 1'b0;
              wrote                 = 1'b1;
            end
          end else if (idle_chk >= cfg.off_timeout_ms) begin
            nxt.light_level = '0;
            wrote           = 1'b1;
          end else if (idle_chk >= cfg.dim_timeout_ms) begin
            nxt.light_level = cfg.dimmed_brightness;
            wrote           = 1'b1;
          end
        end
      end
      OP_ACTIVITY: begin
        if (st.running && !st.locked) begin
          nxt.last_activity_ms = item.now_ms;
          nxt.light_level      = cfg.active_brightness;
          wrote                = 1'b1;
        end
      end
      OP_POWER: begin
        if (st.running && st.locked) begin
          if (st.interaction_light && (idle < st.locked_duration_ms)) begin
            remaining = st.locked_duration_ms - idle;
          end
          nxt.locked_duration_ms = (remaining > POWER_CHANGE_MIN_MS) ?
                                   remaining : POWER_CHANGE_MIN_MS;
          nxt.last_activity_ms   = item.now_ms;
          nxt.light_level        = cfg.active_brightness;
          wrote                  = 1'b1;
        end
      end
      OP_INTERACTION: begin
        if (st.running && st.locked) begin
          nxt.locked_duration_ms = cfg.interaction_duration_ms;
          nxt.interaction_light  = 1'b1;
          nxt.last_activity_ms   = item.now_ms;
          nxt.light_level        = cfg.active_brightness;
          wrote                  = 1'b1;
        end
      end
      OP_TOGGLE: begin
        if (st.running && st.locked) begin
          nxt.interaction_light = 1'b0;
          wrote                 = 1'b1;
          if (st.light_level != '0) begin
            nxt.light_level = '0;
          end else begin
            nxt.locked_duration_ms = cfg.interaction_duration_ms;
            nxt.last_activity_ms   = item.now_ms;
            nxt.light_level        = cfg.active_brightness;
          end
        end
      end
      OP_SET_LOCK: begin
        if (st.running && (st.locked != item.lock_request)) begin
          nxt.locked             = item.lock_request;
          nxt.interaction_light  = 1'b0;
          nxt.locked_duration_ms = cfg.lock_timeout_ms;
          wrote                  = 1'b1;
          if (!item.lock_request || (!st.has_locked && item.reason_manual)) begin
            // unlock, or first manual lock, lights up
            nxt.last_activity_ms = item.now_ms;
            nxt.light_level      = cfg.active_brightness;
          end else begin
            nxt.light_level = '0;
          end
          if (item.lock_request) begin
            nxt.has_locked = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // idle time as seen after the event, zero if it just activated
  assign idle_after = (nxt.last_activity_ms == item.now_ms) ? '0 : idle;

  assign st_next = nxt;

  // result record
  assign res.brightness         = nxt.light_level;
  assign res.brightness_written = wrote;
  assign res.start_ok           = start_ok;
  assign res.is_running         = nxt.running;
  assign res.is_locked          = nxt.locked;
  assign res.idle_lock_due      = nxt.running && !nxt.locked &&
                                  (idle_after >= cfg.off_timeout_ms);

endmodule

/* hw/rtl/frontlight_idle_lock_timer.sv */
// ----------------------------------------------------------------------------
// frontlight_idle_lock_timer
// Frontlight dim/off and lock-screen light timer with stream ports.
// ----------------------------------------------------------------------------
// Takes one event request per clock and gives exactly one result request for
// each, in order. An accepted event is held in the input register, is
// evaluated against the timer state by the event logic and lands in the
// result register together with the state update, so events may follow
// back to back at one per cycle while results are taken. The throughput
// is set by the state loop from the state register through the event
// logic (one wrapping subtraction and a few compares). Both stages hold
// when the result is not taken. Configuration writes take effect at the
// next edge and are meant for when no event is in flight.
// ----------------------------------------------------------------------------
module frontlight_idle_lock_timer
  import filt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // event requests
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // now_ms[31:0], light_ready[32], button_pressed[33], input_activity[34],
  // lock_request[35], reason_manual[36], zero fill [39:37]
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // operation[2:0]
  input  logic [IN_USER_W-1:0]   s_tuser,
  // result requests
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // brightness[7:0], brightness_written[8], start_ok[9], is_running[10],
  // is_locked[11], idle_lock_due[12], zero fill [15:13]
  output logic [OUT_DATA_W-1:0]  m_tdata,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   in_item;
  logic    in_valid;
  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    advance;

  filt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  filt_event u_event (
    .st      (st),
    .cfg     (cfg),
    .item    (in_item),
    .st_next (st_next),
    .res     (res)
  );

  // handshake control
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.operation      <= op_t'(s_tuser);
      in_item.now_ms         <= s_tdata[31:0];
      in_item.light_ready    <= s_tdata[32];
      in_item.button_pressed <= s_tdata[33];
      in_item.input_activity <= s_tdata[34];
      in_item.lock_request   <= s_tdata[35];
      in_item.reason_manual  <= s_tdata[36];
    end
  end

  // timer state, updated as each event moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res};

endmodule

/* hw/rtl/filt_checker.sv */
// ----------------------------------------------------------------------------
// filt_checker
// Port-level checks of the frontlight timer: result hold under back-pressure,
// consistency of the result flags and the latency from event to result.
// ----------------------------------------------------------------------------
module filt_checker
  import filt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a successful start always leaves the timer running
  a_start_running: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[9] || m_tdata[10]))
    else $error("start_ok without running");

  // idle lock is only due while running and unlocked
  a_due_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> m_tdata[10] && !m_tdata[11])
    else $error("idle lock due while stopped or locked");

  // an event taken while no result waits shows a result once it has passed the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid)
    else $error("result missing after accepted event");

endmodule

bind frontlight_idle_lock_timer filt_checker u_filt_checker (.*);
